// ----- rtl/clp_pkg.sv -----
// Shared types, constants and key lookup for the Content-Length header parser.
`default_nettype none

package clp_pkg;

  localparam int KEY_LEN     = 14;
  localparam int KEY_CNT_W   = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef struct packed {
    logic       eos;
    logic       newline;
    logic       cr;
    logic       zero;
    logic       colon;
    logic       space;
    logic       plus;
    logic       minus;
    logic       digit;
    logic [3:0] digit_value;
    logic [7:0] lower;
  } token_t;

  typedef enum logic [2:0] {
    LINE_KEY    = 3'b001,
    LINE_VALUE  = 3'b010,
    LINE_IGNORE = 3'b100
  } line_phase_t;

  typedef enum logic [2:0] {
    BLANK_START = 3'b001,
    BLANK_CR    = 3'b010,
    BLANK_NOT   = 3'b100
  } blank_track_t;

  typedef enum logic [3:0] {
    NUM_SKIP   = 4'b0001,
    NUM_SIGN   = 4'b0010,
    NUM_DIGITS = 4'b0100,
    NUM_DONE   = 4'b1000
  } num_phase_t;

  function automatic logic [7:0] key_char(input logic [KEY_CNT_W-1:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = "c";
      4'd1:    c = "o";
      4'd2:    c = "n";
      4'd3:    c = "t";
      4'd4:    c = "e";
      4'd5:    c = "n";
      4'd6:    c = "t";
      4'd7:    c = "-";
      4'd8:    c = "l";
      4'd9:    c = "e";
      4'd10:   c = "n";
      4'd11:   c = "g";
      4'd12:   c = "t";
      4'd13:   c = "h";
      default: c = CHAR_NUL;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/clp_front.sv -----
// Front end: accepts header bytes and classifies each into a token for the queue.
`default_nettype none

module clp_front (
  input  wire logic          byte_valid,
  input  wire logic [7:0]    data_byte,
  input  wire logic          end_of_stream,
  input  wire logic          queue_full,
  output logic               byte_stall,
  output logic               push,
  output clp_pkg::token_t    tok
);
  import clp_pkg::*;

  assign byte_stall = queue_full;
  assign push       = byte_valid && !queue_full;

  always_comb begin
    tok.eos         = end_of_stream;
    tok.newline     = (data_byte == CHAR_LF);
    tok.cr          = (data_byte == CHAR_CR);
    tok.zero        = (data_byte == CHAR_NUL);
    tok.colon       = (data_byte == CHAR_COLON);
    tok.space       = data_byte inside {8'h20, [8'h09:8'h0D]};
    tok.plus        = (data_byte == CHAR_PLUS);
    tok.minus       = (data_byte == CHAR_MINUS);
    tok.digit       = data_byte inside {["0":"9"]};
    tok.digit_value = data_byte[3:0];
    tok.lower       = (data_byte inside {["A":"Z"]}) ? (data_byte + 8'd32) : data_byte;
  end

endmodule

`default_nettype wire

// ----- rtl/clp_queue.sv -----
// Short token queue between the front end and the line engine.
`default_nettype none

module clp_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire clp_pkg::token_t  push_tok,
  input  wire logic             pop,
  output clp_pkg::token_t       head_tok,
  output logic                  full,
  output logic                  not_empty
);
  import clp_pkg::*;

  token_t                 slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;

  assign full      = (count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head_tok  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/clp_back.sv -----
// Line engine: matches the key, converts the value and issues the length request.
`default_nettype none

module clp_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire clp_pkg::token_t tok,
  input  wire logic            tok_valid,
  output logic                 pop,
  input  wire logic            length_stall,
  output logic                 length_valid,
  output logic signed [31:0]   content_length,
  output logic                 end_kind,
  output logic                 saturated
);
  import clp_pkg::*;

  line_phase_t          line_phase, line_phase_next;
  logic [KEY_CNT_W-1:0] key_count, key_count_next;
  logic                 key_matching, key_matching_next;
  blank_track_t         blank_track, blank_track_next;
  num_phase_t           num_phase, num_phase_next;
  logic                 num_negative, num_negative_next;
  logic [31:0]          num_mag, num_mag_next;
  logic                 num_clamped, num_clamped_next;
  logic                 key_hit, key_hit_next;
  logic [31:0]          held_length, held_length_next;
  logic                 held_clamped, held_clamped_next;

  logic                 ready;
  logic                 emit;
  logic                 emit_kind;
  logic [31:0]          fin_length;
  logic                 fin_clamped;
  logic [35:0]          acc;
  logic [31:0]          limit;
  logic                 take_digit;

  assign ready = !length_valid || !length_stall;
  assign pop   = tok_valid && ready;

  assign limit = num_negative ? NEG_LIMIT : POS_LIMIT;
  assign acc   = {1'b0, num_mag, 3'b000} + {3'b000, num_mag, 1'b0}
               + {32'd0, tok.digit_value};

  always_comb begin
    fin_length  = held_length;
    fin_clamped = held_clamped;
    if (key_hit) begin
      fin_length  = num_negative ? (32'd0 - num_mag) : num_mag;
      fin_clamped = num_clamped;
    end
  end

  always_comb begin
    line_phase_next   = line_phase;
    key_count_next    = key_count;
    key_matching_next = key_matching;
    blank_track_next  = blank_track;
    num_phase_next    = num_phase;
    num_negative_next = num_negative;
    num_mag_next      = num_mag;
    num_clamped_next  = num_clamped;
    key_hit_next      = key_hit;
    held_length_next  = held_length;
    held_clamped_next = held_clamped;
    emit              = 1'b0;
    emit_kind         = 1'b0;
    take_digit        = 1'b0;

    if (tok.eos || tok.newline) begin
      emit              = tok.eos || (blank_track == BLANK_CR);
      emit_kind         = tok.eos;
      line_phase_next   = LINE_KEY;
      key_count_next    = '0;
      key_matching_next = 1'b1;
      blank_track_next  = BLANK_START;
      num_phase_next    = NUM_SKIP;
      num_negative_next = 1'b0;
      num_mag_next      = '0;
      num_clamped_next  = 1'b0;
      key_hit_next      = 1'b0;
      held_length_next  = emit ? 32'd0 : fin_length;
      held_clamped_next = emit ? 1'b0 : fin_clamped;
    end else begin
      if (blank_track == BLANK_START && tok.cr && line_phase != LINE_IGNORE) begin
        blank_track_next = BLANK_CR;
      end else begin
        blank_track_next = BLANK_NOT;
      end

      if (line_phase == LINE_IGNORE) begin
        line_phase_next = LINE_IGNORE;
      end else if (tok.zero) begin
        line_phase_next = LINE_IGNORE;
      end else if (line_phase == LINE_KEY) begin
        if (tok.colon) begin
          key_hit_next    = key_matching && (key_count == KEY_CNT_W'(KEY_LEN));
          line_phase_next = LINE_VALUE;
        end else if (key_count < KEY_CNT_W'(KEY_LEN) && tok.lower == key_char(key_count)) begin
          key_count_next = key_count + 1'b1;
        end else begin
          key_matching_next = 1'b0;
        end
      end else begin
        case (num_phase)
          NUM_SKIP: begin
            if (tok.space) begin
              num_phase_next = NUM_SKIP;
            end else if (tok.plus || tok.minus) begin
              num_negative_next = tok.minus;
              num_phase_next    = NUM_SIGN;
            end else begin
              num_phase_next = tok.digit ? NUM_DIGITS : NUM_DONE;
              take_digit     = tok.digit;
            end
          end
          NUM_SIGN: begin
            num_phase_next = tok.digit ? NUM_DIGITS : NUM_DONE;
            take_digit     = tok.digit;
          end
          NUM_DIGITS: begin
            num_phase_next = tok.digit ? NUM_DIGITS : NUM_DONE;
            take_digit     = tok.digit;
          end
          default: begin
            num_phase_next = NUM_DONE;
          end
        endcase
        if (take_digit) begin
          if (acc > {4'd0, limit}) begin
            num_mag_next     = limit;
            num_clamped_next = 1'b1;
          end else begin
            num_mag_next = acc[31:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_phase   <= LINE_KEY;
      key_count    <= '0;
      key_matching <= 1'b1;
      blank_track  <= BLANK_START;
      num_phase    <= NUM_SKIP;
      num_negative <= 1'b0;
      num_mag      <= '0;
      num_clamped  <= 1'b0;
      key_hit      <= 1'b0;
      held_length  <= '0;
      held_clamped <= 1'b0;
      length_valid <= 1'b0;
    end else begin
      if (pop) begin
        line_phase   <= line_phase_next;
        key_count    <= key_count_next;
        key_matching <= key_matching_next;
        blank_track  <= blank_track_next;
        num_phase    <= num_phase_next;
        num_negative <= num_negative_next;
        num_mag      <= num_mag_next;
        num_clamped  <= num_clamped_next;
        key_hit      <= key_hit_next;
        held_length  <= held_length_next;
        held_clamped <= held_clamped_next;
      end
      if (pop && emit) begin
        length_valid <= 1'b1;
      end else if (!length_stall) begin
        length_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      content_length <= fin_length;
      end_kind       <= emit_kind;
      saturated      <= fin_clamped;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/content_length_header_parser.sv -----
// Top level of the HTTP Content-Length header parser.
// Takes one header byte per cycle while byte_stall is low, with end_of_stream closing the header.
// A front end classifies each byte into a four-entry token queue; the line engine retires one
// token per cycle while the output is not stalled, so the rate is set by that state update (key
// match, multiply-by-ten accumulate). With the queue empty, the byte ending the header (blank CR
// LF line or stream end) is written into the queue, and the length request is registered at the
// output when the line engine pops it, after any tokens still queued ahead of it; byte_stall
// rises only when the queue fills while the output side is stalled.
`default_nettype none

module content_length_header_parser (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               byte_valid,
  output logic                    byte_stall,
  input  wire logic [7:0]         data_byte,
  input  wire logic               end_of_stream,
  output logic                    length_valid,
  input  wire logic               length_stall,
  output logic signed [31:0]      content_length,
  output logic                    end_kind,
  output logic                    saturated
);
  import clp_pkg::*;

  token_t front_tok;
  token_t head_tok;
  logic   push;
  logic   pop;
  logic   queue_full;
  logic   queue_not_empty;

  clp_front u_front (
    .byte_valid    (byte_valid),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .queue_full    (queue_full),
    .byte_stall    (byte_stall),
    .push          (push),
    .tok           (front_tok)
  );

  clp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_tok  (front_tok),
    .pop       (pop),
    .head_tok  (head_tok),
    .full      (queue_full),
    .not_empty (queue_not_empty)
  );

  clp_back u_back (
    .clk            (clk),
    .rst            (rst),
    .tok            (head_tok),
    .tok_valid      (queue_not_empty),
    .pop            (pop),
    .length_stall   (length_stall),
    .length_valid   (length_valid),
    .content_length (content_length),
    .end_kind       (end_kind),
    .saturated      (saturated)
  );

endmodule

`default_nettype wire

// ----- tb/tb_content_length_header_parser.sv -----
// Self-checking testbench for the Content-Length header parser: byte stream in, length out.
`timescale 1ns / 100ps

module tb_content_length_header_parser;
  import clp_pkg::*;

  localparam int REQUEST_TARGET = 1550;
  localparam int LENGTH_TARGET  = 40;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 10;

  class length_predictor;
    typedef struct {
      logic [31:0] len;
      logic        kind;
      logic        sat;
    } length_result_t;

    length_result_t expected_lengths[$];
    string          key_name = "content-length";
    int             errors;
    int             lengths_checked;
    int             saturated_seen;
    int             stream_ends_seen;

    line_phase_t    phase;
    blank_track_t   blank;
    num_phase_t     num_phase;
    logic [3:0]     key_count;
    logic           key_ok;
    logic           negative;
    logic [31:0]    magnitude;
    logic           clamped;
    logic           key_hit;
    logic [31:0]    held_length;
    logic           held_sat;

    function new();
      clear_line();
      held_length = '0;
      held_sat    = 1'b0;
    endfunction

    function void clear_line();
      phase     = LINE_KEY;
      blank     = BLANK_START;
      num_phase = NUM_SKIP;
      key_count = '0;
      key_ok    = 1'b1;
      negative  = 1'b0;
      magnitude = '0;
      clamped   = 1'b0;
      key_hit   = 1'b0;
    endfunction

    function void close_line();
      if (key_hit) begin
        held_length = negative ? -magnitude : magnitude;
        held_sat    = clamped;
      end
      clear_line();
    endfunction

    function void push_length(logic kind);
      length_result_t r;
      r.len  = held_length;
      r.kind = kind;
      r.sat  = held_sat;
      expected_lengths.push_back(r);
      clear_line();
      held_length = '0;
      held_sat    = 1'b0;
    endfunction

    function void take_value_byte(logic [7:0] b);
      logic        digit;
      logic        space;
      logic [63:0] limit;
      logic [63:0] next_mag;
      digit = (b >= "0" && b <= "9");
      space = (b == " ") || (b >= 8'h09 && b <= CHAR_CR);
      if (num_phase == NUM_SKIP) begin
        if (space) return;
        if (b == CHAR_PLUS || b == CHAR_MINUS) begin
          negative  = (b == CHAR_MINUS);
          num_phase = NUM_SIGN;
          return;
        end
        num_phase = digit ? NUM_DIGITS : NUM_DONE;
      end else if (num_phase == NUM_SIGN) begin
        num_phase = digit ? NUM_DIGITS : NUM_DONE;
      end else if (num_phase == NUM_DIGITS && !digit) begin
        num_phase = NUM_DONE;
      end
      if (num_phase == NUM_DIGITS) begin
        limit    = negative ? {32'd0, NEG_LIMIT} : {32'd0, POS_LIMIT};
        next_mag = {32'd0, magnitude} * 64'd10 + {56'd0, b - 8'h30};
        if (next_mag > limit) begin
          next_mag = limit;
          clamped  = 1'b1;
        end
        magnitude = next_mag[31:0];
      end
    endfunction

    function void note_request(logic [7:0] b, logic eos);
      logic was_blank;
      if (eos) begin
        close_line();
        push_length(1'b1);
        return;
      end
      if (b == CHAR_LF) begin
        was_blank = (blank == BLANK_CR);
        close_line();
        if (was_blank) push_length(1'b0);
        return;
      end
      if (blank == BLANK_START && b == CHAR_CR && phase != LINE_IGNORE) blank = BLANK_CR;
      else blank = BLANK_NOT;
      if (phase == LINE_IGNORE) return;
      if (b == CHAR_NUL) begin
        phase = LINE_IGNORE;
        return;
      end
      if (phase == LINE_KEY) begin
        if (b == CHAR_COLON) begin
          key_hit = key_ok && (key_count == KEY_LEN);
          phase   = LINE_VALUE;
        end else if (key_count < KEY_LEN &&
                     ((b >= "A" && b <= "Z") ? b + 8'd32 : b) == key_name[key_count]) begin
          key_count++;
        end else begin
          key_ok = 1'b0;
        end
      end else begin
        take_value_byte(b);
      end
    endfunction

    function void check_length(logic [31:0] len, logic kind, logic sat);
      length_result_t r;
      if (expected_lengths.size() == 0) begin
        $display("%0t: unexpected length %0d kind %0b saturated %0b", $time,
                 $signed(len), kind, sat);
        errors++;
        return;
      end
      r = expected_lengths.pop_front();
      lengths_checked++;
      if (r.sat) saturated_seen++;
      if (r.kind) stream_ends_seen++;
      if (len !== r.len) begin
        $display("%0t: content_length expected %0d actual %0d", $time,
                 $signed(r.len), $signed(len));
        errors++;
      end
      if (kind !== r.kind) begin
        $display("%0t: end_kind expected %0b actual %0b", $time, r.kind, kind);
        errors++;
      end
      if (sat !== r.sat) begin
        $display("%0t: saturated expected %0b actual %0b", $time, r.sat, sat);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               byte_valid = 1'b0;
  logic               byte_stall;
  logic [7:0]         data_byte = 8'h00;
  logic               end_of_stream = 1'b0;
  logic               length_valid;
  logic               length_stall = 1'b0;
  logic signed [31:0] content_length;
  logic               end_kind;
  logic               saturated;

  length_predictor lengths = new();
  int              request_count = 0;
  int              idle_cycles = 0;
  int              burst_left = 0;
  int              stall_count = 0;
  logic [1:0]      stall_mode = 2'd0;

  content_length_header_parser u_top (
    .clk            (clk),
    .rst            (rst),
    .byte_valid     (byte_valid),
    .byte_stall     (byte_stall),
    .data_byte      (data_byte),
    .end_of_stream  (end_of_stream),
    .length_valid   (length_valid),
    .length_stall   (length_stall),
    .content_length (content_length),
    .end_kind       (end_kind),
    .saturated      (saturated)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (stall_count == 0) begin
      stall_mode  <= 2'($urandom_range(0, 3));
      stall_count <= $urandom_range(50, 400);
    end else begin
      stall_count <= stall_count - 1;
    end
    case (stall_mode)
      2'd0: length_stall <= 1'b0;
      2'd1: length_stall <= 1'($urandom_range(0, 1));
      2'd2: length_stall <= ($urandom_range(0, 7) != 0);
      default: length_stall <= stall_count[3];
    endcase
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (byte_valid && !byte_stall) begin
        lengths.note_request(data_byte, end_of_stream);
        request_count++;
      end
      if (length_valid && !length_stall) begin
        lengths.check_length(content_length, end_kind, saturated);
      end
      if ((byte_valid && !byte_stall) || (length_valid && !length_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("content_length_header_parser: mismatch");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [7:0] b, input logic eos);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        byte_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    byte_valid    <= 1'b1;
    data_byte     <= b;
    end_of_stream <= eos;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_request(s[i], 1'b0);
  endtask

  task automatic send_eos();
    send_request(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic end_line(input logic crlf);
    if (crlf) send_request(CHAR_CR, 1'b0);
    send_request(CHAR_LF, 1'b0);
  endtask

  function automatic string fold_case(input string s);
    string r;
    r = s;
    for (int i = 0; i < r.len(); i++) begin
      if (r[i] >= "a" && r[i] <= "z" && $urandom_range(0, 1)) r[i] = r[i] - 8'd32;
    end
    return r;
  endfunction

  function automatic string number_text();
    string s;
    s = "";
    case ($urandom_range(0, 7))
      0: s = $sformatf("%0d", $urandom_range(0, 999));
      1: s = $sformatf("%0d", $urandom());
      2: begin
        case ($urandom_range(0, 3))
          0: s = "2147483647";
          1: s = "2147483648";
          2: s = "2147483649";
          default: s = "4294967296";
        endcase
      end
      3: repeat ($urandom_range(11, 16)) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
      4: s = "";
      5: s = $sformatf("000%0d", $urandom_range(0, 99));
      6: s = $sformatf("%0d", $urandom_range(0, 99999999));
      default: repeat ($urandom_range(1, 10)) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
    endcase
    return s;
  endfunction

  task automatic send_leading_space();
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 4))
        0: send_request(" ", 1'b0);
        1: send_request(8'h09, 1'b0);
        2: send_request(8'h0B, 1'b0);
        3: send_request(8'h0C, 1'b0);
        default: send_request(CHAR_CR, 1'b0);
      endcase
    end
  endtask

  task automatic send_length_line();
    case ($urandom_range(0, 7))
      5: send_text(fold_case("content-lengt"));
      6: send_text(fold_case("content-lengthh"));
      7: send_text(fold_case(" content-length"));
      default: send_text(fold_case("content-length"));
    endcase
    send_request(CHAR_COLON, 1'b0);
    send_leading_space();
    case ($urandom_range(0, 3))
      0: send_request(CHAR_PLUS, 1'b0);
      1: send_request(CHAR_MINUS, 1'b0);
      default: ;
    endcase
    send_text(number_text());
    case ($urandom_range(0, 5))
      0: send_text(" ;x");
      1: send_text("7a9");
      2: begin
        send_request(CHAR_NUL, 1'b0);
        send_text("12");
      end
      3: send_text(":5");
      default: ;
    endcase
  endtask

  task automatic send_line();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: send_length_line();
      4: send_text(fold_case(($urandom_range(0, 1)) ? "x-length: 5" : "accept: */*"));
      5: send_text(fold_case("content-length 42"));
      6: repeat ($urandom_range(1, 8)) send_request(8'($urandom_range(0, 255)), 1'b0);
      7: ;
      8: begin
        if ($urandom_range(0, 1)) send_request(CHAR_NUL, 1'b0);
        send_request(CHAR_CR, 1'b0);
        if ($urandom_range(0, 1)) send_text(" x");
      end
      default: send_text(fold_case(($urandom_range(0, 1)) ? "content-length :5"
                                                          : "content-length:"));
    endcase
  endtask

  task automatic send_header();
    repeat ($urandom_range(0, 4)) begin
      send_line();
      end_line($urandom_range(0, 3) != 0);
    end
    case ($urandom_range(0, 3))
      0: send_eos();
      1: begin
        send_line();
        send_eos();
      end
      default: end_line(1'b1);
    endcase
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_eos();
    end_line(1'b1);
    end_line(1'b0);
    send_eos();
    send_text("Content-Length:+");
    send_eos();
    send_text("CONTENT-LENGTH:99999999999");
    end_line(1'b1);
    end_line(1'b1);
    send_text("content-length:-2147483648");
    send_request(CHAR_NUL, 1'b0);
    send_text("7");
    send_eos();
    send_text("content-length:-9999999999");
    send_request(8'hFF, 1'b1);

    while (request_count < REQUEST_TARGET ||
           lengths.lengths_checked + lengths.expected_lengths.size() < LENGTH_TARGET) begin
      send_header();
    end

    byte_valid <= 1'b0;
    @(posedge clk);
    while (lengths.expected_lengths.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d header bytes, checked %0d lengths", request_count,
             lengths.lengths_checked);
    $display("%0d lengths clamped, %0d closed by stream end", lengths.saturated_seen,
             lengths.stream_ends_seen);
    if (lengths.errors == 0) begin
      $display("content_length_header_parser: match");
    end else begin
      $display("content_length_header_parser: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/clp_pkg.sv
rtl/clp_front.sv
rtl/clp_queue.sv
rtl/clp_back.sv
rtl/content_length_header_parser.sv
tb/tb_content_length_header_parser.sv
